FILE: sv/smss_pkg.sv
// Shared types and constants for the stepper move sequencer with stall stop.
package smss_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ROTATE = 2'd1,
        OP_SEEK   = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_FULL_STEPS = 2'd0;
    localparam logic [IDX_W-1:0] REG_STALL_THR  = 2'd1;

    // Field and state widths.
    localparam int CFG_W   = 10;
    localparam int DEG_W   = 16;
    localparam int EMF_W   = 10;
    localparam int MAG_W   = 17;
    localparam int STEPS_W = 32;
    localparam int PHASE_W = 5;

    // Register reset values.
    localparam logic [CFG_W-1:0] FULL_STEPS_RESET = 10'd200;
    localparam logic [CFG_W-1:0] STALL_THR_RESET  = 10'd100;
    localparam logic [EMF_W-1:0] EMF_FULL         = 10'd1023;
    localparam logic [STEPS_W-1:0] ENDLESS_COUNT  = 32'hFFFF_FFFF;

    // Division by 360 is a shift by 3, then a multiply by the reciprocal of 45.
    // The quotient is exact for every dividend below 2^29 after the shift.
    localparam int PRE_SHIFT = 3;
    localparam int Y_W       = STEPS_W - PRE_SHIFT;
    localparam int RECIP_W   = 30;
    localparam int QP_W      = Y_W + RECIP_W;
    localparam int DIV_SHIFT = 35;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 30'd763549742;

    // A decoded command on its way to the motion state.
    typedef struct packed {
        op_t                op;
        logic               dir;
        logic [EMF_W-1:0]   emf;
        logic [STEPS_W-1:0] count;
    } cmd_t;

    // One result item; the last member sits in the lowest bit.
    typedef struct packed {
        logic driver_awake;
        logic moving;
        logic stalled;
        logic emf_used;
        logic direction_out;
        logic step_pulse;
    } result_t;

endpackage

FILE: sv/smss_count_pipe.sv
// Three-stage front end that turns a rotate angle into a microstep count.
module smss_count_pipe #(
    parameter int FM_W = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Incoming item
    input  logic                               in_valid,
    output logic                               in_ready,
    input  smss_pkg::op_t                      in_op,
    input  logic signed [smss_pkg::DEG_W-1:0]  in_degrees,
    input  logic                               in_direction,
    input  logic [smss_pkg::EMF_W-1:0]         in_emf,
    // Full steps per revolution times microsteps
    input  logic [FM_W-1:0]                    steps_scale,
    // Decoded command
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output smss_pkg::cmd_t                     cmd
);

    localparam int XP_W = smss_pkg::MAG_W + FM_W;

    // Stage 1: registered input item.
    logic                          s1_valid_reg;
    smss_pkg::op_t                 s1_op_reg;
    logic [smss_pkg::DEG_W-1:0]    s1_deg_reg;
    logic                          s1_dir_reg;
    logic [smss_pkg::EMF_W-1:0]    s1_emf_reg;

    // Stage 2: scaled angle.
    logic                          s2_valid_reg;
    smss_pkg::op_t                 s2_op_reg;
    logic                          s2_dir_reg;
    logic [smss_pkg::EMF_W-1:0]    s2_emf_reg;
    logic [smss_pkg::STEPS_W-1:0]  s2_x_reg;

    // Stage 3: finished command.
    logic                          s3_valid_reg;
    smss_pkg::cmd_t                s3_cmd_reg;

    logic                          ready1, ready2, ready3;
    logic                          neg;
    logic [smss_pkg::MAG_W-1:0]    mag;
    logic                          cmd_dir;
    logic [XP_W-1:0]               x_prod;
    logic [smss_pkg::Y_W-1:0]      y_val;
    logic [smss_pkg::QP_W-1:0]     q_prod;

    // Each stage takes a new item when it is empty or its successor moves.
    assign ready3   = !s3_valid_reg || cmd_ready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_ready = ready1;

    // Magnitude of the angle and the direction a rotate command sets.
    always_comb begin
        neg     = s1_deg_reg[smss_pkg::DEG_W-1];
        mag     = neg ? (17'h10000 - {1'b0, s1_deg_reg}) : {1'b0, s1_deg_reg};
        cmd_dir = (s1_op_reg == smss_pkg::OP_ROTATE) ?
                  (!neg && (s1_deg_reg != '0)) : s1_dir_reg;
        x_prod  = XP_W'(mag) * XP_W'(steps_scale);
    end

    // Divide the scaled angle by 360.
    always_comb begin
        y_val  = s2_x_reg[smss_pkg::STEPS_W-1:smss_pkg::PRE_SHIFT];
        q_prod = smss_pkg::QP_W'(y_val) * smss_pkg::QP_W'(smss_pkg::DIV_RECIP);
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (ready1) begin
                s1_valid_reg <= in_valid;
            end
            if (ready2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ready1) begin
            s1_op_reg  <= in_op;
            s1_deg_reg <= in_degrees;
            s1_dir_reg <= in_direction;
            s1_emf_reg <= in_emf;
        end
        if (ready2) begin
            s2_op_reg  <= s1_op_reg;
            s2_dir_reg <= cmd_dir;
            s2_emf_reg <= s1_emf_reg;
            s2_x_reg   <= smss_pkg::STEPS_W'(x_prod);
        end
        if (ready3) begin
            s3_cmd_reg.op    <= s2_op_reg;
            s3_cmd_reg.dir   <= s2_dir_reg;
            s3_cmd_reg.emf   <= s2_emf_reg;
            s3_cmd_reg.count <= smss_pkg::STEPS_W'(
                q_prod[smss_pkg::QP_W-1:smss_pkg::DIV_SHIFT]);
        end
    end

    assign cmd_valid = s3_valid_reg;
    assign cmd       = s3_cmd_reg;

endmodule

FILE: sv/smss_motion_core.sv
// Motion state: step count, microstep phase, back-EMF average and run control.
module smss_motion_core #(
    parameter int MICROSTEPS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [smss_pkg::CFG_W-1:0]  stall_threshold,
    // Decoded command
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  smss_pkg::cmd_t              cmd,
    // Result item
    output logic                        res_valid,
    input  logic                        res_ready,
    output smss_pkg::result_t           res
);

    localparam int PHASES = 1 << smss_pkg::PHASE_W;

    logic [smss_pkg::STEPS_W-1:0] remaining_reg, remaining_next;
    logic [smss_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [smss_pkg::EMF_W-1:0]   avg_reg, avg_next;
    logic                         run_reg, run_next;
    logic                         ticking_reg, ticking_next;
    logic                         dir_reg, dir_next;
    logic                         sense_reg, sense_next;
    logic                         res_valid_reg;
    smss_pkg::result_t            res_reg, res_next;

    logic                         fire;
    logic                         run_after;
    logic [11:0]                  blend_sum;
    logic [smss_pkg::EMF_W-1:0]   avg_blend;
    logic [PHASES-1:0]            bound_mask;

    // Phases that fall on a full-step boundary.
    for (genvar p = 0; p < PHASES; p++) begin : g_bound
        assign bound_mask[p] = ((p % MICROSTEPS) == 0);
    end

    assign cmd_ready = !res_valid_reg || res_ready;
    assign fire      = cmd_valid && cmd_ready;

    // Running average of the back-EMF: (avg * 3 + sample) / 4.
    always_comb begin
        blend_sum = 12'({avg_reg, 1'b0}) + 12'(avg_reg) + 12'(cmd.emf);
        avg_blend = blend_sum[11:2];
    end

    // Next state and result for the command at hand.
    always_comb begin
        remaining_next = remaining_reg;
        phase_next     = phase_reg;
        avg_next       = avg_reg;
        run_next       = run_reg;
        ticking_next   = ticking_reg;
        dir_next       = dir_reg;
        sense_next     = sense_reg;
        run_after      = run_reg;
        res_next       = '0;
        case (cmd.op)
            smss_pkg::OP_ROTATE: begin
                dir_next       = cmd.dir;
                remaining_next = cmd.count;
                sense_next     = 1'b0;
                if (!run_reg) begin
                    run_next     = 1'b1;
                    ticking_next = 1'b1;
                end
            end
            smss_pkg::OP_SEEK: begin
                dir_next       = cmd.dir;
                remaining_next = smss_pkg::ENDLESS_COUNT;
                sense_next     = 1'b1;
                if (!run_reg) begin
                    run_next     = 1'b1;
                    ticking_next = 1'b1;
                end
            end
            smss_pkg::OP_STOP: begin
                run_next = 1'b0;
            end
            default: begin
                // Timer tick; nothing happens while the tick source sleeps.
                if (ticking_reg) begin
                    if (remaining_reg != '0) begin
                        res_next.step_pulse = 1'b1;
                        if (sense_reg && bound_mask[phase_reg]) begin
                            res_next.emf_used = 1'b1;
                            avg_next          = avg_blend;
                            if (avg_blend <= stall_threshold) begin
                                res_next.stalled = 1'b1;
                                run_after        = 1'b0;
                            end
                        end
                        phase_next     = dir_reg ? phase_reg + 5'd1 : phase_reg - 5'd1;
                        remaining_next = remaining_reg - 32'd1;
                    end else begin
                        run_after = 1'b0;
                    end
                    run_next = run_after;
                    // Halting puts the driver to sleep and resets the average.
                    if (!run_after) begin
                        avg_next     = smss_pkg::EMF_FULL;
                        ticking_next = 1'b0;
                    end
                end
            end
        endcase
        res_next.direction_out = dir_next;
        res_next.moving        = run_next;
        res_next.driver_awake  = ticking_next;
    end

    // Control state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            phase_reg     <= '0;
            avg_reg       <= smss_pkg::EMF_FULL;
            run_reg       <= 1'b0;
            ticking_reg   <= 1'b0;
            dir_reg       <= 1'b0;
            sense_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                remaining_reg <= remaining_next;
                phase_reg     <= phase_next;
                avg_reg       <= avg_next;
                run_reg       <= run_next;
                ticking_reg   <= ticking_next;
                dir_reg       <= dir_next;
                sense_reg     <= sense_next;
            end
            if (cmd_ready) begin
                res_valid_reg <= cmd_valid;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: sv/stepper_move_with_stall_stop_unit.sv
// Top level of the stepper move sequencer with back-EMF stall stop.
// Throughput: one item per cycle while m_tready does not hold back a waiting result;
// the angle scaling and the divide by 360 are split over three pipeline registers
// ahead of the motion state update and its result register.
// Reset: synchronous, active low; clears the pipeline, the motion state and
// restores full_steps_per_rev to 200 and stall_threshold to 100.
module stepper_move_with_stall_stop_unit #(
    parameter int MICROSTEPS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port
    input  logic                        cfg_we,
    input  logic [smss_pkg::IDX_W-1:0]  cfg_index,
    input  logic [smss_pkg::CFG_W-1:0]  cfg_data,
    // Input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: operation[1:0], degrees[17:2], direction[18], emf_sample[28:19], zero[31:29]
    input  logic [31:0]                 s_tdata,
    // Result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: step_pulse[0], direction_out[1], emf_used[2], stalled[3], moving[4],
    // driver_awake[5], zero[7:6]
    output logic [7:0]                  m_tdata
);

    localparam int FM_W = smss_pkg::CFG_W + $clog2(MICROSTEPS);

    logic [FM_W-1:0]              scale_reg, scale_next;
    logic [smss_pkg::CFG_W-1:0]   thr_reg, thr_next;

    logic                         cmd_valid;
    logic                         cmd_ready;
    smss_pkg::cmd_t               cmd;
    smss_pkg::result_t            res;

    // Configuration writes; the steps register is kept premultiplied by MICROSTEPS.
    always_comb begin
        scale_next = scale_reg;
        thr_next   = thr_reg;
        if (cfg_we) begin
            case (cfg_index)
                smss_pkg::REG_FULL_STEPS: scale_next = FM_W'(cfg_data * MICROSTEPS);
                smss_pkg::REG_STALL_THR:  thr_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= FM_W'(smss_pkg::FULL_STEPS_RESET * MICROSTEPS);
            thr_reg   <= smss_pkg::STALL_THR_RESET;
        end else begin
            scale_reg <= scale_next;
            thr_reg   <= thr_next;
        end
    end

    // Angle to microstep count.
    smss_count_pipe #(
        .FM_W (FM_W)
    ) u_count_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (smss_pkg::op_t'(s_tdata[1:0])),
        .in_degrees   (s_tdata[17:2]),
        .in_direction (s_tdata[18]),
        .in_emf       (s_tdata[28:19]),
        .steps_scale  (scale_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    // Motion state and result register.
    smss_motion_core #(
        .MICROSTEPS (MICROSTEPS)
    ) u_motion_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .stall_threshold (thr_reg),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res             (res)
    );

    assign m_tdata = {2'b00, res};

endmodule
